FILE: rtl/mtlb_pkg.sv
`timescale 1ns / 1ps

package mtlb_pkg;

   // store size and field widths
   localparam int ENTRIES      = 64;
   localparam int CONTEXT_BITS = 12;
   localparam int TAG_W        = 20;
   localparam int SLOT_W       = 6;
   localparam int CTXIN_W      = 12;
   localparam int PTE_W        = 32;
   localparam int LVL_W        = 2;
   localparam int TYPE_W       = 2;

   // derived widths
   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int CTX_W  = (CONTEXT_BITS < CTXIN_W) ? CONTEXT_BITS : CTXIN_W;
   localparam int SW_W   = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

   // two-level priority pick: groups of eight entries
   localparam int GRP    = 8;
   localparam int GRP_W  = 3;
   localparam int NGRP   = (ENTRIES + GRP - 1) / GRP;
   localparam int PAD    = NGRP * GRP;
   localparam int PIDX_W = $clog2(PAD);
   localparam int HS_W   = (PIDX_W > SLOT_W) ? PIDX_W : SLOT_W;

   // request kinds
   localparam logic [TYPE_W-1:0] REQ_LOOKUP = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_WRITE  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_UPDATE = 2'd2;

   // page table levels
   localparam logic [LVL_W-1:0] LVL_0 = 2'd0;
   localparam logic [LVL_W-1:0] LVL_1 = 2'd1;
   localparam logic [LVL_W-1:0] LVL_2 = 2'd2;
   localparam logic [LVL_W-1:0] LVL_3 = 2'd3;

   // low pte bits of a valid entry
   localparam logic [1:0] VALID_CODE = 2'b10;

   // controller to datapath commands
   typedef struct packed {
      logic look;     // lookup transfer: latch match vector
      logic wr_full;  // write transfer: store whole entry
      logic wr_pte;   // update transfer: store pte only
      logic grp;      // per-group first match
      logic pick;     // global pick and entry read
      logic rsp;      // load result registers
   } mtlb_cmd_type;

   // tag with the bits below the level's page size cleared
   function automatic logic [TAG_W-1:0] tag_for_level(input logic [TAG_W-1:0] tag,
                                                      input logic [LVL_W-1:0] lvl);
      logic [TAG_W-1:0] res;
      case (lvl)
         LVL_3:   res = tag;
         LVL_2:   res = {tag[TAG_W-1:6], 6'd0};
         LVL_1:   res = {tag[TAG_W-1:12], 12'd0};
         default: res = '0;
      endcase
      return res;
   endfunction

endpackage

FILE: rtl/mtlb_ram.sv
`timescale 1ns / 1ps

module mtlb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mtlb_ctrl.sv
`timescale 1ns / 1ps

module mtlb_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mtlb_pkg::TYPE_W-1:0]  req_type,
   output logic                         busy,
   output mtlb_pkg::mtlb_cmd_type       cmd
);

   import mtlb_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GRP,
      ST_PICK,
      ST_READ
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;
   logic      busy_in;
   logic      accept;

   assign accept = start && !busy_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_LOOKUP: begin
                     cmd.look = 1'b1;
                     state_in = ST_GRP;
                  end
                  REQ_WRITE:  cmd.wr_full = 1'b1;
                  REQ_UPDATE: cmd.wr_pte  = 1'b1;
                  default:    ;
               endcase
            end
         end
         ST_GRP: begin
            cmd.grp  = 1'b1;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.rsp  = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy_in = (state_in != ST_IDLE);

   // state and busy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

   // a lookup transfer holds the block busy through the group, pick and read states
   a_look_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_type == REQ_LOOKUP |=> busy ##1 busy ##1 busy ##1 !busy)
      else $error("lookup did not hold busy for three cycles");

   // write and update finish in their own cycle
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_type == REQ_WRITE || req_type == REQ_UPDATE) |=> !busy)
      else $error("write or update left the block busy");

   // at most one command at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.look, cmd.wr_full, cmd.wr_pte, cmd.grp, cmd.pick, cmd.rsp}))
      else $error("more than one command issued");

endmodule

FILE: rtl/mtlb_dpath.sv
`timescale 1ns / 1ps

module mtlb_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  mtlb_pkg::mtlb_cmd_type        cmd,
   input  logic [mtlb_pkg::SLOT_W-1:0]   req_slot,
   input  logic [mtlb_pkg::TAG_W-1:0]    req_virt_tag,
   input  logic [mtlb_pkg::CTXIN_W-1:0]  req_context_id,
   input  logic [mtlb_pkg::PTE_W-1:0]    req_page_entry,
   input  logic [mtlb_pkg::LVL_W-1:0]    req_entry_level,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic [mtlb_pkg::SLOT_W-1:0]   rsp_hit_slot,
   output logic [mtlb_pkg::PTE_W-1:0]    rsp_hit_entry,
   output logic [mtlb_pkg::LVL_W-1:0]    rsp_hit_level
);

   import mtlb_pkg::*;

   // per-entry compare state
   logic [TAG_W-1:0] tag_ff [ENTRIES];
   logic [CTX_W-1:0] ctx_ff [ENTRIES];
   logic [LVL_W-1:0] lvl_ff [ENTRIES];
   logic [ENTRIES-1:0] vld_ff;
   logic [ENTRIES-1:0] lvw_ff;

   // lookup pipeline
   logic [ENTRIES-1:0] match_in;
   logic [ENTRIES-1:0] match_ff;
   logic [PAD-1:0]     match_pad;
   logic [NGRP-1:0]    grp_any_in;
   logic [NGRP-1:0]    grp_any_ff;
   logic [GRP_W-1:0]   grp_first_in [NGRP];
   logic [GRP_W-1:0]   grp_first_ff [NGRP];
   logic               hit_in;
   logic               hit_ff;
   logic [PIDX_W-1:0]  pick_in;
   logic [PIDX_W-1:0]  pick_ff;
   logic [HS_W-1:0]    pick_wide;

   // result registers
   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [SLOT_W-1:0]  rsp_hit_slot_ff;
   logic [PTE_W-1:0]   rsp_hit_entry_ff;
   logic [LVL_W-1:0]   rsp_hit_level_ff;

   // write address decode
   logic [SW_W-1:0]    slot_wide;
   logic [IDX_W-1:0]   wr_idx;
   logic               in_range;
   logic [CTX_W-1:0]   req_ctx;
   logic [PTE_W-1:0]   pte_q;
   logic [LVL_W-1:0]   lvl_q;

   assign slot_wide = SW_W'(req_slot);
   assign wr_idx    = slot_wide[IDX_W-1:0];
   assign in_range  = ({1'b0, slot_wide} < (SW_W + 1)'(ENTRIES));
   assign req_ctx   = req_context_id[CTX_W-1:0];

   // entry store: tag, context, level and valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            tag_ff[i] <= '0;
            ctx_ff[i] <= '0;
            lvl_ff[i] <= '0;
         end
         vld_ff <= '0;
         lvw_ff <= '0;
      end else if (in_range) begin
         if (cmd.wr_full) begin
            tag_ff[wr_idx] <= tag_for_level(req_virt_tag, req_entry_level);
            ctx_ff[wr_idx] <= req_ctx;
            lvl_ff[wr_idx] <= req_entry_level;
            vld_ff[wr_idx] <= (req_page_entry[1:0] == VALID_CODE);
            lvw_ff[wr_idx] <= 1'b1;
         end else if (cmd.wr_pte) begin
            vld_ff[wr_idx] <= (req_page_entry[1:0] == VALID_CODE);
         end
      end
   end

   // pte and level words, read at the winning index
   mtlb_ram #(.WIDTH(PTE_W), .DEPTH(ENTRIES)) u_pte_ram (
      .clock   (clock),
      .wr_en   ((cmd.wr_full || cmd.wr_pte) && in_range),
      .wr_addr (wr_idx),
      .wr_data (req_page_entry),
      .rd_en   (cmd.pick),
      .rd_addr (pick_in[IDX_W-1:0]),
      .rd_data (pte_q)
   );

   mtlb_ram #(.WIDTH(LVL_W), .DEPTH(ENTRIES)) u_lvl_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_full && in_range),
      .wr_addr (wr_idx),
      .wr_data (req_entry_level),
      .rd_en   (cmd.pick),
      .rd_addr (pick_in[IDX_W-1:0]),
      .rd_data (lvl_q)
   );

   // parallel compare of every entry, masked by its level
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i] = vld_ff[i] && (ctx_ff[i] == req_ctx) &&
                       (tag_for_level(req_virt_tag, lvl_ff[i]) == tag_ff[i]);
      end
   end

   // first match inside each group of eight
   assign match_pad = PAD'(match_ff);

   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_any_in[g]   = |match_pad[g*GRP +: GRP];
         grp_first_in[g] = '0;
         for (int j = GRP - 1; j >= 0; j--) begin
            if (match_pad[g*GRP + j]) begin
               grp_first_in[g] = GRP_W'(j);
            end
         end
      end
   end

   // lowest group with a match
   always_comb begin
      hit_in  = 1'b0;
      pick_in = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            hit_in  = 1'b1;
            pick_in = PIDX_W'(g * GRP) + PIDX_W'(grp_first_ff[g]);
         end
      end
   end

   assign pick_wide = HS_W'(pick_ff);

   // lookup pipeline registers
   always_ff @(posedge clock) begin
      if (cmd.look) begin
         match_ff <= match_in;
      end
      if (cmd.grp) begin
         grp_any_ff   <= grp_any_in;
         grp_first_ff <= grp_first_in;
      end
      if (cmd.pick) begin
         hit_ff  <= hit_in;
         pick_ff <= pick_in;
      end
   end

   // result transfer, one cycle strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp;
      end
      if (cmd.rsp) begin
         rsp_hit_ff       <= hit_ff;
         rsp_hit_slot_ff  <= hit_ff ? pick_wide[SLOT_W-1:0] : '0;
         rsp_hit_entry_ff <= hit_ff ? pte_q : '0;
         rsp_hit_level_ff <= (hit_ff && lvw_ff[pick_ff[IDX_W-1:0]]) ? lvl_q : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_hit_slot  = rsp_hit_slot_ff;
   assign rsp_hit_entry = rsp_hit_entry_ff;
   assign rsp_hit_level = rsp_hit_level_ff;

   // strobe lasts one cycle
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // a miss carries all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_slot == '0 && rsp_hit_entry == '0 &&
                                rsp_hit_level == '0)
      else $error("miss result with nonzero fields");

   // a hit returns a valid pte
   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_hit_entry[1:0] == VALID_CODE)
      else $error("hit result with invalid pte");

endmodule

FILE: rtl/mmu_tlb_level_masked.sv
`timescale 1ns / 1ps

// Fully associative translation buffer with level-masked tag compare.
// A request transfer is taken at a clock edge with start high and busy low.
// Write and update requests complete in the cycle they are taken, so a new
// request can follow on the next cycle. A lookup holds busy high through
// the group, pick and read states, and the result strobe rsp_valid is high
// for one cycle, the first with busy low again, during which the next
// request may already be taken. Its steps are the parallel compare, the
// two-level lowest-index pick over groups of eight entries and the
// registered read of the entry RAM. The receiver cannot stall: each
// result is present for exactly one cycle. Reset clears every entry at once,
// with no clearing pass. Only lookups produce a result, one per lookup;
// writes and updates that name a slot beyond the store are ignored, and an
// unused request kind changes nothing and produces no result.
module mmu_tlb_level_masked (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [mtlb_pkg::TYPE_W-1:0]   req_type,
   input  logic [mtlb_pkg::SLOT_W-1:0]   req_slot,
   input  logic [mtlb_pkg::TAG_W-1:0]    req_virt_tag,
   input  logic [mtlb_pkg::CTXIN_W-1:0]  req_context_id,
   input  logic [mtlb_pkg::PTE_W-1:0]    req_page_entry,
   input  logic [mtlb_pkg::LVL_W-1:0]    req_entry_level,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic [mtlb_pkg::SLOT_W-1:0]   rsp_hit_slot,
   output logic [mtlb_pkg::PTE_W-1:0]    rsp_hit_entry,
   output logic [mtlb_pkg::LVL_W-1:0]    rsp_hit_level
);

   import mtlb_pkg::*;

   mtlb_cmd_type cmd;

   // sequencer
   mtlb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .busy     (busy),
      .cmd      (cmd)
   );

   // entry store, compare and pick
   mtlb_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_slot        (req_slot),
      .req_virt_tag    (req_virt_tag),
      .req_context_id  (req_context_id),
      .req_page_entry  (req_page_entry),
      .req_entry_level (req_entry_level),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_hit_slot    (rsp_hit_slot),
      .rsp_hit_entry   (rsp_hit_entry),
      .rsp_hit_level   (rsp_hit_level)
   );

endmodule

FILE: tb/mmu_tlb_level_masked_checker.sv
`timescale 1ns / 1ps

module mmu_tlb_level_masked_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [mtlb_pkg::TYPE_W-1:0]   req_type,
   input  logic [mtlb_pkg::SLOT_W-1:0]   req_slot,
   input  logic [mtlb_pkg::TAG_W-1:0]    req_virt_tag,
   input  logic [mtlb_pkg::CTXIN_W-1:0]  req_context_id,
   input  logic [mtlb_pkg::PTE_W-1:0]    req_page_entry,
   input  logic [mtlb_pkg::LVL_W-1:0]    req_entry_level,
   input  logic                          rsp_valid,
   input  logic                          rsp_hit,
   input  logic [mtlb_pkg::SLOT_W-1:0]   rsp_hit_slot,
   input  logic [mtlb_pkg::PTE_W-1:0]    rsp_hit_entry,
   input  logic [mtlb_pkg::LVL_W-1:0]    rsp_hit_level,
   output int                            fail_count,
   output int                            pending_count
);

   import mtlb_pkg::*;

   // context bits that take part in the compare
   localparam logic [31:0] CTX_KEEP = (CTX_W >= 32) ? 32'hFFFF_FFFF
                                                    : ((32'd1 << CTX_W) - 32'd1);

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic [PTE_W-1:0]  entry;
      logic [LVL_W-1:0]  level;
   } translation_type;

   // shadow copy of the translation store
   logic [TAG_W-1:0]   tag_mem   [ENTRIES];
   logic [CTXIN_W-1:0] ctx_mem   [ENTRIES];
   logic [PTE_W-1:0]   pte_mem   [ENTRIES];
   logic [LVL_W-1:0]   level_mem [ENTRIES];

   translation_type pending_lookups [$];
   translation_type want;
   logic [CTXIN_W-1:0] req_ctx;

   // tag bits that a page of the given level keeps
   function automatic logic [TAG_W-1:0] level_tag(input logic [TAG_W-1:0] tag,
                                                  input logic [LVL_W-1:0] lvl);
      logic [TAG_W-1:0] res;
      case (lvl)
         LVL_3:   res = tag;
         LVL_2:   res = tag & 20'hFFFC0;
         LVL_1:   res = tag & 20'hFF000;
         default: res = '0;
      endcase
      return res;
   endfunction

   // lowest valid entry whose context and masked tag match
   function automatic translation_type find_translation(input logic [TAG_W-1:0] tag,
                                                        input logic [CTXIN_W-1:0] ctx);
      translation_type res;
      logic found;
      res = '0;
      found = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!found && pte_mem[i][1:0] == VALID_CODE && ctx_mem[i] == ctx &&
             level_tag(tag, level_mem[i]) == level_tag(tag_mem[i], level_mem[i])) begin
            found     = 1'b1;
            res.hit   = 1'b1;
            res.slot  = SLOT_W'(i);
            res.entry = pte_mem[i];
            res.level = level_mem[i];
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            tag_mem[i]   = '0;
            ctx_mem[i]   = '0;
            pte_mem[i]   = '0;
            level_mem[i] = '0;
         end
         pending_lookups.delete();
         fail_count = 0;
         pending_count <= 0;
      end else begin
         // result transfer against the oldest lookup
         if (rsp_valid) begin
            if (pending_lookups.size() == 0) begin
               $error("result with no lookup outstanding");
               fail_count = fail_count + 1;
            end else begin
               want = pending_lookups.pop_front();
               if (rsp_hit !== want.hit) begin
                  $error("hit mismatch: expected %0d, actual %0d", want.hit, rsp_hit);
                  fail_count = fail_count + 1;
               end
               if (rsp_hit_slot !== want.slot) begin
                  $error("hit_slot mismatch: expected %0d, actual %0d",
                         want.slot, rsp_hit_slot);
                  fail_count = fail_count + 1;
               end
               if (rsp_hit_entry !== want.entry) begin
                  $error("hit_entry mismatch: expected %h, actual %h",
                         want.entry, rsp_hit_entry);
                  fail_count = fail_count + 1;
               end
               if (rsp_hit_level !== want.level) begin
                  $error("hit_level mismatch: expected %0d, actual %0d",
                         want.level, rsp_hit_level);
                  fail_count = fail_count + 1;
               end
            end
         end

         // request transfer updates the shadow store or queues a lookup
         if (start && !busy) begin
            req_ctx = req_context_id & CTX_KEEP[CTXIN_W-1:0];
            case (req_type)
               REQ_LOOKUP: begin
                  pending_lookups.push_back(find_translation(req_virt_tag, req_ctx));
               end
               REQ_WRITE: begin
                  if (int'(req_slot) < ENTRIES) begin
                     tag_mem[req_slot]   = level_tag(req_virt_tag, req_entry_level);
                     ctx_mem[req_slot]   = req_ctx;
                     pte_mem[req_slot]   = req_page_entry;
                     level_mem[req_slot] = req_entry_level;
                  end
               end
               REQ_UPDATE: begin
                  if (int'(req_slot) < ENTRIES)
                     pte_mem[req_slot] = req_page_entry;
               end
               default: ;
            endcase
         end
         pending_count <= pending_lookups.size();
      end
   end

endmodule

FILE: tb/mmu_tlb_level_masked_tb.sv
`timescale 1ns / 1ps

module mmu_tlb_level_masked_tb;

   import mtlb_pkg::*;

   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1900;
   localparam int CYCLE_LIMIT  = 400000;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [TYPE_W-1:0]   req_type;
   logic [SLOT_W-1:0]   req_slot;
   logic [TAG_W-1:0]    req_virt_tag;
   logic [CTXIN_W-1:0]  req_context_id;
   logic [PTE_W-1:0]    req_page_entry;
   logic [LVL_W-1:0]    req_entry_level;
   logic                rsp_valid;
   logic                rsp_hit;
   logic [SLOT_W-1:0]   rsp_hit_slot;
   logic [PTE_W-1:0]    rsp_hit_entry;
   logic [LVL_W-1:0]    rsp_hit_level;

   int fail_count;
   int pending_count;
   int cycle_count;
   int burst_left;

   // small pools so that lookups find what was written
   logic [TAG_W-1:0]   tag_pool [8];
   logic [CTXIN_W-1:0] ctx_pool [4];

   mmu_tlb_level_masked DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_slot        (req_slot),
      .req_virt_tag    (req_virt_tag),
      .req_context_id  (req_context_id),
      .req_page_entry  (req_page_entry),
      .req_entry_level (req_entry_level),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_hit_slot    (rsp_hit_slot),
      .rsp_hit_entry   (rsp_hit_entry),
      .rsp_hit_level   (rsp_hit_level)
   );

   mmu_tlb_level_masked_checker u_tlb_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_slot        (req_slot),
      .req_virt_tag    (req_virt_tag),
      .req_context_id  (req_context_id),
      .req_page_entry  (req_page_entry),
      .req_entry_level (req_entry_level),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_hit_slot    (rsp_hit_slot),
      .rsp_hit_entry   (rsp_hit_entry),
      .rsp_hit_level   (rsp_hit_level),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // one request transfer, start stays high on return
   task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                               input logic [TAG_W-1:0] tag, input logic [CTXIN_W-1:0] ctx,
                               input logic [PTE_W-1:0] pte, input logic [LVL_W-1:0] lvl);
      req_type        <= kind;
      req_slot        <= slot;
      req_virt_tag    <= tag;
      req_context_id  <= ctx;
      req_page_entry  <= pte;
      req_entry_level <= lvl;
      start           <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // mostly short gaps, a few long ones, and stretches with none
   function automatic int idle_length();
      int n;
      n = 0;
      if (burst_left > 0) begin
         burst_left = burst_left - 1;
      end else if ($urandom_range(0, 39) == 0) begin
         burst_left = $urandom_range(20, 60);
      end else if ($urandom_range(0, 9) < 8) begin
         n = $urandom_range(0, 2);
      end else begin
         n = $urandom_range(5, 40);
      end
      return n;
   endfunction

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // hold off until every lookup result has come back
   task automatic drain_lookups();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int pick;
      logic [TYPE_W-1:0]  kind;
      logic [SLOT_W-1:0]  slot;
      logic [TAG_W-1:0]   tag;
      logic [CTXIN_W-1:0] ctx;
      logic [PTE_W-1:0]   pte;
      logic [LVL_W-1:0]   lvl;

      clock           = 1'b0;
      reset           = 1'b1;
      start           = 1'b0;
      req_type        = REQ_LOOKUP;
      req_slot        = '0;
      req_virt_tag    = '0;
      req_context_id  = '0;
      req_page_entry  = '0;
      req_entry_level = LVL_0;
      cycle_count     = 0;
      burst_left      = 0;

      for (int i = 0; i < 8; i++) tag_pool[i] = TAG_W'($urandom);
      ctx_pool[0] = '0;
      ctx_pool[1] = '1;
      ctx_pool[2] = CTXIN_W'($urandom);
      ctx_pool[3] = CTXIN_W'($urandom);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty store, exact match, context, level masks, updates, priority, unused kind, invalid pte
      send_request(REQ_LOOKUP, 6'd0, 20'h00000, 12'h000, 32'h0, LVL_0);
      idle_cycles(idle_length());
      send_request(REQ_WRITE, 6'd63, 20'hFFFFF, 12'hFFF, 32'hFFFF_FFFE, LVL_3);
      send_request(REQ_LOOKUP, 6'd0, 20'hFFFFF, 12'hFFF, 32'h0, LVL_0);
      send_request(REQ_LOOKUP, 6'd0, 20'hFFFFE, 12'hFFF, 32'h0, LVL_0);
      idle_cycles(idle_length());
      send_request(REQ_LOOKUP, 6'd0, 20'hFFFFF, 12'h000, 32'h0, LVL_0);
      // level 0 entry matches any tag
      send_request(REQ_WRITE, 6'd0, 20'h12345, 12'h005, 32'h0000_0002, LVL_0);
      send_request(REQ_LOOKUP, 6'd17, 20'h00000, 12'h005, 32'h0, LVL_3);
      // level 2 keeps tag bits above 5
      send_request(REQ_WRITE, 6'd10, 20'h12345, 12'h006, 32'hCAFE_0002, LVL_2);
      idle_cycles(idle_length());
      send_request(REQ_LOOKUP, 6'd0, 20'h1237F, 12'h006, 32'h0, LVL_0);
      send_request(REQ_LOOKUP, 6'd0, 20'h12380, 12'h006, 32'h0, LVL_0);
      // level 1 keeps tag bits above 11
      send_request(REQ_WRITE, 6'd20, 20'hABCDE, 12'h007, 32'h0000_1002, LVL_1);
      send_request(REQ_LOOKUP, 6'd0, 20'hAB000, 12'h007, 32'h0, LVL_0);
      // update turns the entry invalid, then valid again
      send_request(REQ_UPDATE, 6'd20, 20'h0, 12'h0, 32'h0000_1003, LVL_0);
      send_request(REQ_LOOKUP, 6'd0, 20'hABFFF, 12'h007, 32'h0, LVL_0);
      idle_cycles(idle_length());
      send_request(REQ_UPDATE, 6'd20, 20'hFFFFF, 12'hFFF, 32'hFFFF_FFF2, LVL_3);
      send_request(REQ_LOOKUP, 6'd0, 20'hABC00, 12'h007, 32'h0, LVL_0);
      // several matches: lowest slot wins
      send_request(REQ_WRITE, 6'd40, 20'hABCDE, 12'h007, 32'h0000_0012, LVL_3);
      send_request(REQ_WRITE, 6'd3, 20'hAB000, 12'h007, 32'h0000_0006, LVL_1);
      send_request(REQ_LOOKUP, 6'd0, 20'hABCDE, 12'h007, 32'h0, LVL_0);
      // unused request kind leaves the store alone
      send_request(REQ_UNUSED, 6'd3, 20'h0, 12'h007, 32'h0, LVL_0);
      send_request(REQ_LOOKUP, 6'd0, 20'hABCDE, 12'h007, 32'h0, LVL_0);
      send_request(REQ_WRITE, 6'd3, 20'hAB000, 12'h007, 32'h0000_0001, LVL_1);
      send_request(REQ_LOOKUP, 6'd0, 20'hABCDE, 12'h007, 32'h0, LVL_0);
      // zero pte is invalid
      send_request(REQ_WRITE, 6'd1, 20'h0, 12'h000, 32'h0, LVL_0);
      send_request(REQ_LOOKUP, 6'd0, 20'h0, 12'h000, 32'h0, LVL_0);
      drain_lookups();

      // random: mostly pool tags and contexts so lookups hit, plus noise
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)      kind = REQ_LOOKUP;
         else if (pick < 75) kind = REQ_WRITE;
         else if (pick < 93) kind = REQ_UPDATE;
         else                kind = REQ_UNUSED;

         if ($urandom_range(0, 1) == 0) slot = SLOT_W'($urandom_range(0, 7));
         else                           slot = SLOT_W'($urandom_range(0, 63));

         if ($urandom_range(0, 9) < 8) begin
            tag = tag_pool[$urandom_range(0, 7)];
            if ($urandom_range(0, 1) == 0) tag[11:0] = 12'($urandom);
         end else begin
            tag = TAG_W'($urandom);
         end

         if ($urandom_range(0, 19) < 17) ctx = ctx_pool[$urandom_range(0, 3)];
         else                            ctx = CTXIN_W'($urandom);

         pte = $urandom;
         if ($urandom_range(0, 3) != 0) pte[1:0] = VALID_CODE;
         lvl = LVL_W'($urandom_range(0, 3));

         send_request(kind, slot, tag, ctx, pte, lvl);
         sent = sent + 1;

         if (sent % 300 == 299) drain_lookups();
         else                   idle_cycles(idle_length());
      end

      drain_lookups();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/mtlb_pkg.sv
rtl/mtlb_ram.sv
rtl/mtlb_ctrl.sv
rtl/mtlb_dpath.sv
rtl/mmu_tlb_level_masked.sv
tb/mmu_tlb_level_masked_checker.sv
tb/mmu_tlb_level_masked_tb.sv
